// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros; each samples on clk and is disabled while rst_n
// is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds
`define RGBF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante
`define RGBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rgbfade_pkg.sv =====
// ---------------------------------------------------------------------------
// rgbfade_pkg
// Register map, reset values and field widths of the RGB fade PWM core.
// ---------------------------------------------------------------------------
package rgbfade_pkg;

  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned REG_IDX_W = 3;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_RED_FLOOR    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GREEN_FLOOR  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BLUE_FLOOR   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FADE_STEP    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TICKS_PER_PD = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_HOLD_PERIODS = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_OFF_PERIODS  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_LONG_OFF     = 3'd7;

  // Register reset values
  localparam logic [LEVEL_W-1:0] RST_FLOOR        = 8'd102;
  localparam logic [LEVEL_W-1:0] RST_FADE_STEP    = 8'd1;
  localparam logic [LEVEL_W-1:0] RST_TICKS_PER_PD = 8'd250;
  localparam logic [LEVEL_W-1:0] RST_HOLD_PERIODS = 8'd2;
  localparam logic [LEVEL_W-1:0] RST_OFF_PERIODS  = 8'd6;

  // Fully dark level
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

endpackage

// ===== hdl/rgb_led_fade_pwm_controller_core.sv =====
// ---------------------------------------------------------------------------
// rgb_led_fade_pwm_controller_core
// RGB breathing fade controller with a shared software-style PWM counter.
// ---------------------------------------------------------------------------
//  Channel | Dir | Ports            | Contents
//  --------+-----+------------------+--------------------------------------
//  in      | in  | in_t*            | fade_tick, pwm_tick per request
//  out     | out | out_t*           | lit bits, levels, phase per request
//  cfg     | in  | cfg_p*           | seven 8-bit registers and a 1-bit flag, APB style
//
//  One request is taken per cycle while in_tready is high; its result is registered and shown on the
//  cycle after acceptance. The single output register sets the figure.
//  in_tready drops only while a result waits and out_tready is low.
//  Synchronous active-low reset returns the fade to UP, all levels dark.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_led_fade_pwm_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [0] fade_tick, [1] pwm_tick, [7:2] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // out_tdata: [0] red_lit, [1] green_lit, [2] blue_lit, [10:3] red_level,
  //            [18:11] green_level, [26:19] blue_level, [28:27] phase, [31:29] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [1:0] {
    PH_UP   = 2'd0,
    PH_HOLD = 2'd1,
    PH_DOWN = 2'd2,
    PH_OFF  = 2'd3
  } phase_t;

  typedef logic [rgbfade_pkg::LEVEL_W-1:0] level_t;

  // Configuration registers
  level_t red_floor_r, green_floor_r, blue_floor_r, fade_step_r;
  level_t ticks_per_pd_r, hold_periods_r, off_periods_r;
  logic   long_off_r;

  // Fade state
  phase_t phase_r, phase_nxt;
  level_t period_timer_r, period_timer_nxt;
  level_t period_count_r, period_count_nxt;
  level_t red_lvl_r, green_lvl_r, blue_lvl_r;
  level_t red_lvl_nxt, green_lvl_nxt, blue_lvl_nxt;
  level_t pwm_counter_r, pwm_counter_nxt;

  // Result register
  logic        out_valid_r;
  logic [31:0] out_data_r, out_data_nxt;

  logic [rgbfade_pkg::REG_IDX_W-1:0] cfg_idx;
  logic cfg_wr;
  logic in_acc;
  logic fade_tick, pwm_tick;
  logic [rgbfade_pkg::LEVEL_W:0] timer_inc, count_inc;
  logic wrap, hold_done, off_done, dark;
  logic red_lit, green_lit, blue_lit;

  // Step the level down by stp toward its floor, saturating there
  function automatic level_t step_down(level_t lvl, level_t flr, level_t stp);
    level_t gap;
    gap = lvl - flr;
    if (lvl > flr) begin
      step_down = (stp >= gap) ? flr : level_t'(lvl - stp);
    end else begin
      step_down = lvl;
    end
  endfunction

  // Step the level up by stp toward fully dark, saturating there
  function automatic level_t step_up(level_t lvl, level_t stp);
    logic [rgbfade_pkg::LEVEL_W:0] sum;
    sum = {1'b0, lvl} + {1'b0, stp};
    step_up = sum[rgbfade_pkg::LEVEL_W] ? rgbfade_pkg::LEVEL_MAX
                                        : sum[rgbfade_pkg::LEVEL_W-1:0];
  endfunction

  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;

  // Read back the addressed register
  always_comb begin
    cfg_prdata = '0;
    case (cfg_idx)
      rgbfade_pkg::REG_RED_FLOOR:    cfg_prdata[7:0] = red_floor_r;
      rgbfade_pkg::REG_GREEN_FLOOR:  cfg_prdata[7:0] = green_floor_r;
      rgbfade_pkg::REG_BLUE_FLOOR:   cfg_prdata[7:0] = blue_floor_r;
      rgbfade_pkg::REG_FADE_STEP:    cfg_prdata[7:0] = fade_step_r;
      rgbfade_pkg::REG_TICKS_PER_PD: cfg_prdata[7:0] = ticks_per_pd_r;
      rgbfade_pkg::REG_HOLD_PERIODS: cfg_prdata[7:0] = hold_periods_r;
      rgbfade_pkg::REG_OFF_PERIODS:  cfg_prdata[7:0] = off_periods_r;
      rgbfade_pkg::REG_LONG_OFF:     cfg_prdata[0]   = long_off_r;
      default:                       cfg_prdata      = '0;
    endcase
  end

  // Accept while the result register is empty or being drained
  assign in_tready  = ~out_valid_r | out_tready;
  assign in_acc     = in_tvalid & in_tready;
  assign fade_tick  = in_tdata[0];
  assign pwm_tick   = in_tdata[1];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Period timer and wrap counter
  assign timer_inc = {1'b0, period_timer_r} + 9'd1;
  assign wrap      = (timer_inc >= {1'b0, ticks_per_pd_r});
  assign count_inc = {1'b0, period_count_r} + 9'd1;
  assign hold_done = (count_inc >= {1'b0, hold_periods_r});
  assign off_done  = (count_inc >= {1'b0, off_periods_r});

  // Phase machine and level stepping for one request
  always_comb begin
    phase_nxt        = phase_r;
    period_timer_nxt = period_timer_r;
    period_count_nxt = period_count_r;
    red_lvl_nxt      = red_lvl_r;
    green_lvl_nxt    = green_lvl_r;
    blue_lvl_nxt     = blue_lvl_r;
    if (fade_tick) begin
      period_timer_nxt = wrap ? '0 : timer_inc[rgbfade_pkg::LEVEL_W-1:0];
      case (phase_r)
        PH_UP: begin
          red_lvl_nxt   = step_down(red_lvl_r, red_floor_r, fade_step_r);
          green_lvl_nxt = step_down(green_lvl_r, green_floor_r, fade_step_r);
          blue_lvl_nxt  = step_down(blue_lvl_r, blue_floor_r, fade_step_r);
          if (wrap) phase_nxt = PH_HOLD;
        end
        PH_HOLD: begin
          if (wrap) begin
            period_count_nxt = hold_done ? '0 : count_inc[rgbfade_pkg::LEVEL_W-1:0];
            if (hold_done) phase_nxt = PH_DOWN;
          end
        end
        PH_DOWN: begin
          red_lvl_nxt   = step_up(red_lvl_r, fade_step_r);
          green_lvl_nxt = step_up(green_lvl_r, fade_step_r);
          blue_lvl_nxt  = step_up(blue_lvl_r, fade_step_r);
          if (wrap) phase_nxt = PH_OFF;
        end
        PH_OFF: begin
          if (long_off_r) begin
            if (wrap) begin
              period_count_nxt = off_done ? '0 : count_inc[rgbfade_pkg::LEVEL_W-1:0];
              if (off_done) phase_nxt = PH_UP;
            end
          end else begin
            period_count_nxt = '0;
            phase_nxt        = PH_UP;
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Form lit bits from the stepped levels, then advance the PWM counter
  assign dark      = (phase_nxt == PH_OFF);
  assign red_lit   = ~dark & (pwm_counter_r > red_lvl_nxt);
  assign green_lit = ~dark & (pwm_counter_r > green_lvl_nxt);
  assign blue_lit  = ~dark & (pwm_counter_r > blue_lvl_nxt);
  assign pwm_counter_nxt = (pwm_tick & ~dark) ? level_t'(pwm_counter_r + 8'd1)
                                              : pwm_counter_r;
  assign out_data_nxt = {3'b000, phase_nxt, blue_lvl_nxt, green_lvl_nxt, red_lvl_nxt,
                         blue_lit, green_lit, red_lit};

  // Hold configuration, fade state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_floor_r    <= rgbfade_pkg::RST_FLOOR;
      green_floor_r  <= rgbfade_pkg::RST_FLOOR;
      blue_floor_r   <= rgbfade_pkg::RST_FLOOR;
      fade_step_r    <= rgbfade_pkg::RST_FADE_STEP;
      ticks_per_pd_r <= rgbfade_pkg::RST_TICKS_PER_PD;
      hold_periods_r <= rgbfade_pkg::RST_HOLD_PERIODS;
      off_periods_r  <= rgbfade_pkg::RST_OFF_PERIODS;
      long_off_r     <= 1'b0;
      phase_r        <= PH_UP;
      period_timer_r <= '0;
      period_count_r <= '0;
      red_lvl_r      <= rgbfade_pkg::LEVEL_MAX;
      green_lvl_r    <= rgbfade_pkg::LEVEL_MAX;
      blue_lvl_r     <= rgbfade_pkg::LEVEL_MAX;
      pwm_counter_r  <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          rgbfade_pkg::REG_RED_FLOOR:    red_floor_r    <= cfg_pwdata[7:0];
          rgbfade_pkg::REG_GREEN_FLOOR:  green_floor_r  <= cfg_pwdata[7:0];
          rgbfade_pkg::REG_BLUE_FLOOR:   blue_floor_r   <= cfg_pwdata[7:0];
          rgbfade_pkg::REG_FADE_STEP:    fade_step_r    <= cfg_pwdata[7:0];
          rgbfade_pkg::REG_TICKS_PER_PD: ticks_per_pd_r <= cfg_pwdata[7:0];
          rgbfade_pkg::REG_HOLD_PERIODS: hold_periods_r <= cfg_pwdata[7:0];
          rgbfade_pkg::REG_OFF_PERIODS:  off_periods_r  <= cfg_pwdata[7:0];
          rgbfade_pkg::REG_LONG_OFF:     long_off_r     <= cfg_pwdata[0];
          default:                       long_off_r     <= long_off_r;
        endcase
      end
      if (in_acc) begin
        phase_r        <= phase_nxt;
        period_timer_r <= period_timer_nxt;
        period_count_r <= period_count_nxt;
        red_lvl_r      <= red_lvl_nxt;
        green_lvl_r    <= green_lvl_nxt;
        blue_lvl_r     <= blue_lvl_nxt;
        pwm_counter_r  <= pwm_counter_nxt;
        out_data_r     <= out_data_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_tready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  // Checks on the core's own logic
  `RGBF_ASSERT_SAME(a_ready_when_empty, !out_valid_r, in_tready, "in_tready low with empty output")
  `RGBF_ASSERT_SAME(a_dark_in_off, out_valid_r && out_data_r[28:27] == PH_OFF, out_data_r[2:0] == 3'b000, "LED lit in OFF phase")
  `RGBF_ASSERT_NEXT(a_pwm_frozen_off, in_acc && phase_nxt == PH_OFF, pwm_counter_r == $past(pwm_counter_r), "PWM counter moved in OFF")
  `RGBF_ASSERT_NEXT(a_short_off_exit, in_acc && fade_tick && phase_r == PH_OFF && !long_off_r, phase_r == PH_UP && period_count_r == '0, "short OFF did not restart UP")

endmodule
